// ----- hw/rtl/lca_pkg.sv -----
//------------------------------------------------------------------------------
// lca_pkg
// Shared constants for the LED cross fade animator.
//------------------------------------------------------------------------------
package lca_pkg;

   // Animation kinds.
   localparam logic [1:0] KIND_NONE = 2'd0;
   localparam logic [1:0] KIND_ON   = 2'd1;
   localparam logic [1:0] KIND_FADE = 2'd2;

   // Input functions.
   localparam logic FUNC_TICK  = 1'b0;
   localparam logic FUNC_START = 1'b1;

   // Brightness percent as a function of the saturated level.
   function automatic logic [6:0] bright_pct(input logic [2:0] lvl);
      case (lvl)
         3'd0:    bright_pct = 7'd0;
         3'd1:    bright_pct = 7'd20;
         3'd2:    bright_pct = 7'd50;
         3'd3:    bright_pct = 7'd70;
         default: bright_pct = 7'd100;
      endcase
   endfunction

   // Physical pixel position of a logical LED slot.
   function automatic logic [5:0] pos_map(input logic [5:0] idx);
      case (idx)
         6'd0:    pos_map = 6'd2;
         6'd1:    pos_map = 6'd1;
         6'd2:    pos_map = 6'd0;
         6'd6:    pos_map = 6'd8;
         6'd8:    pos_map = 6'd6;
         6'd12:   pos_map = 6'd14;
         6'd14:   pos_map = 6'd12;
         default: pos_map = idx;
      endcase
   endfunction

   // Scale an 8-bit color by percent / 100 with truncation.
   // x/100 == (x*5243) >> 19 for x < 43690.
   function automatic logic [7:0] scale8(input logic [7:0] v, input logic [6:0] pct);
      logic [14:0] p;
      logic [27:0] q;
      p = 15'(v) * 15'(pct);
      q = 28'(p) * 28'd5243;
      scale8 = q[26:19];
   endfunction

endpackage

// ----- hw/rtl/lca_ram.sv -----
//------------------------------------------------------------------------------
// lca_ram
// Generic single-port-write, single-port-read RAM with registered read.
//------------------------------------------------------------------------------
module lca_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   // Write and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// ----- hw/rtl/lca_div.sv -----
//------------------------------------------------------------------------------
// lca_div
// Restoring divider of a signed dividend by an 8-bit unsigned divisor.
// One quotient bit per cycle; quotient truncates toward zero.
//------------------------------------------------------------------------------
module lca_div #(
   parameter int W = 26
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic signed [W-1:0] dividend,
   input  logic [7:0]          divisor,
   output logic                done,
   output logic signed [W-1:0] quotient
);
   logic [W-1:0]         mag_ff, mag_in;
   logic [8:0]           rem_ff, rem_in;
   logic [7:0]           dvs_ff, dvs_in;
   logic                 neg_ff, neg_in;
   logic [$clog2(W+1)-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [8:0]           trial;

   // One shift-subtract step per cycle.
   always_comb begin
      mag_in  = mag_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[7:0], mag_ff[W-1]};
      if (start) begin
         neg_in  = dividend[W-1];
         mag_in  = dividend[W-1] ? W'(-dividend) : W'(dividend);
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = ($clog2(W+1))'(W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = trial - {1'b0, dvs_ff};
            mag_in = {mag_ff[W-2:0], 1'b1};
         end else begin
            rem_in = trial;
            mag_in = {mag_ff[W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == ($clog2(W+1))'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      mag_ff <= mag_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      neg_ff <= neg_in;
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? -$signed(mag_ff) : $signed(mag_ff);

   // A result only ever follows a running division.
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff)) else $error("divider done without work");
   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      busy_ff && !start |=> busy_ff || done_ff) else $error("divider dropped work");
   a_count_live: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> cnt_ff != '0) else $error("divider count exhausted while busy");
endmodule

// ----- hw/rtl/led_crossfade_animator_unit.sv -----
//------------------------------------------------------------------------------
// led_crossfade_animator_unit
// Per-LED RGB animation table with a fixed-point linear cross fade.
//------------------------------------------------------------------------------
// Usage:
//   req_ channel: one beat is a start (func = 1) or a frame tick (func = 0).
//   A start beat loads one LED slot and yields no rsp_ beats. A cross fade
//   with a nonzero duration runs three serial divisions.
//   A tick beat increments the frame counter, then walks every LED entry
//   (read, update and write-back states per LED, as the state memory read
//   is registered), then streams min(LED_COUNT, 15) rsp_ beats from the
//   frame store, each through a read state and a send state, holding while
//   rsp_ready is low; last marks the final pixel. One beat is handled at a
//   time; req_ready is low while busy.
//   csr_ channel: brightness level write, taken at any time (always ready).
// Reset: synchronous. It clears the control state and then runs a clearing
//   pass over the LED state memory and the frame store; no req_ beat is
//   taken during that pass.
// Stall: while rsp_ready is low the current pixel holds; the block waits.
//------------------------------------------------------------------------------
module led_crossfade_animator_unit
   import lca_pkg::*;
#(
   parameter int LED_COUNT = 15,
   parameter int FRAC_BITS = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_func,
   input  logic [3:0] req_led,
   input  logic [7:0] req_target_red,
   input  logic [7:0] req_target_green,
   input  logic [7:0] req_target_blue,
   input  logic [1:0] req_anim_kind,
   input  logic [7:0] req_duration,
   input  logic [7:0] req_start_delay,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [3:0] rsp_position,
   output logic [7:0] rsp_out_red,
   output logic [7:0] rsp_out_green,
   output logic [7:0] rsp_out_blue,
   output logic       rsp_last,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [2:0] csr_brightness_level
);
   localparam int CW    = FRAC_BITS + 9;            // signed current value
   localparam int SW    = FRAC_BITS + 10;           // signed step
   localparam int AW    = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
   localparam int NPIX  = (LED_COUNT < 15) ? LED_COUNT : 15;
   localparam int PW    = (NPIX > 1) ? $clog2(NPIX) : 1;
   localparam int PD    = 1 << PW;
   localparam int EW    = 2 + 3 * CW + 3 * SW + 24 + 32 + 8;
   localparam int PXW   = 24;

   // One LED entry of the state memory.
   typedef struct packed {
      logic [1:0]            kind;
      logic signed [CW-1:0]  cur_r;
      logic signed [CW-1:0]  cur_g;
      logic signed [CW-1:0]  cur_b;
      logic signed [SW-1:0]  stp_r;
      logic signed [SW-1:0]  stp_g;
      logic signed [SW-1:0]  stp_b;
      logic [23:0]           tgt;
      logic [31:0]           sframe;
      logic [7:0]            dur;
   } entry_type;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_S_RD, ST_S_DIV, ST_S_WAIT, ST_S_WR,
      ST_T_RD, ST_T_UPD, ST_T_WR, ST_O_RD, ST_O_SEND, ST_O_LAST
   } state_type;

   state_type   state_ff, state_in;
   logic [2:0]  bright_ff;
   logic [31:0] frame_ff, frame_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic [PW-1:0] pix_ff, pix_in;
   logic [1:0]  ch_ff, ch_in;
   entry_type   ent_ff, ent_in;
   logic [3:0]  led_ff;
   logic [23:0] rq_tgt_ff;
   logic [1:0]  rq_kind_ff;
   logic [7:0]  rq_dur_ff, rq_dly_ff;
   logic [7:0]  o_r_ff, o_g_ff, o_b_ff;
   logic        o_last_ff;
   logic [PW-1:0] o_pos_ff;
   logic        rsp_valid_ff;
   logic        load_px;

   // Memory ports.
   logic          e_we;
   logic [AW-1:0] e_wa, e_ra;
   entry_type     e_wd, e_rd;
   logic          f_we;
   logic [PW-1:0] f_wa, f_ra;
   logic [PXW-1:0] f_wd, f_rd;

   lca_ram #(.WIDTH(EW), .DEPTH(LED_COUNT)) u_entry_ram (
      .clock(clock), .wr_en(e_we), .wr_addr(e_wa), .wr_data(e_wd),
      .rd_addr(e_ra), .rd_data(e_rd));

   lca_ram #(.WIDTH(PXW), .DEPTH(PD)) u_frame_ram (
      .clock(clock), .wr_en(f_we), .wr_addr(f_wa), .wr_data(f_wd),
      .rd_addr(f_ra), .rd_data(f_rd));

   // Divider shared over the three channels.
   logic                 div_start, div_done;
   logic signed [SW-1:0] div_num, div_q;

   lca_div #(.W(SW)) u_div (
      .clock(clock), .reset(reset), .start(div_start), .dividend(div_num),
      .divisor(rq_dur_ff), .done(div_done), .quotient(div_q));

   // Helpers for the update step.
   logic signed [SW:0]   sum_r, sum_g, sum_b;
   logic signed [CW-1:0] cl_r, cl_g, cl_b;
   logic signed [31:0]   dlt;
   logic [2:0]           lvl;
   logic [6:0]           pct;
   logic [5:0]           pmap;
   logic signed [CW-1:0] cur_sel;
   logic [7:0]           tgt_sel;

   function automatic logic signed [CW-1:0] clampf(input logic signed [SW:0] v);
      logic signed [SW:0] fs;
      fs = (SW+1)'(255) <<< FRAC_BITS;
      if (v > fs)            clampf = CW'(fs);
      else if (v < 0)        clampf = '0;
      else                   clampf = CW'(v);
   endfunction

   function automatic logic signed [CW-1:0] tfx(input logic [7:0] t);
      tfx = CW'({1'b0, t}) <<< FRAC_BITS;
   endfunction

   always_comb begin
      sum_r = (SW+1)'(ent_ff.cur_r) + (SW+1)'(ent_ff.stp_r);
      sum_g = (SW+1)'(ent_ff.cur_g) + (SW+1)'(ent_ff.stp_g);
      sum_b = (SW+1)'(ent_ff.cur_b) + (SW+1)'(ent_ff.stp_b);
      cl_r  = clampf(sum_r);
      cl_g  = clampf(sum_g);
      cl_b  = clampf(sum_b);
      dlt   = $signed(frame_ff - e_rd.sframe);
      lvl   = (bright_ff > 3'd4) ? 3'd4 : bright_ff;
      pct   = bright_pct(lvl);
      pmap  = pos_map(6'(idx_ff));
      // The red division starts from the extra cycle marked by channel 3.
      case (ch_ff)
         2'd0, 2'd3: begin cur_sel = ent_ff.cur_r; tgt_sel = rq_tgt_ff[23:16]; end
         2'd1:    begin cur_sel = ent_ff.cur_g; tgt_sel = rq_tgt_ff[15:8];  end
         default: begin cur_sel = ent_ff.cur_b; tgt_sel = rq_tgt_ff[7:0];   end
      endcase
      div_num = SW'(tfx(tgt_sel)) - SW'(cur_sel);
   end

   // A pixel moves into the output register when that register is empty or its pixel is being taken.
   assign load_px = (state_ff == ST_O_SEND) && (!rsp_valid_ff || rsp_ready);

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      frame_in = frame_ff;
      idx_in   = idx_ff;
      pix_in   = pix_ff;
      ch_in    = ch_ff;
      ent_in   = ent_ff;
      e_we = 1'b0; e_wa = idx_ff; e_wd = ent_ff; e_ra = idx_ff;
      f_we = 1'b0; f_wa = PW'(pmap); f_wd = '0; f_ra = pix_ff;
      div_start = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            e_we = 1'b1; e_wd = '0;
            f_we = 1'b1; f_wa = PW'(idx_ff);
            if (32'(idx_ff) == LED_COUNT - 1) begin
               state_in = ST_IDLE;
               idx_in = '0;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            idx_in = '0;
            if (req_valid) begin
               if (req_func == FUNC_START) begin
                  idx_in = AW'(req_led);
                  state_in = (32'(req_led) < LED_COUNT) ? ST_S_RD : ST_IDLE;
               end else begin
                  frame_in = frame_ff + 32'd1;
                  state_in = ST_T_RD;
               end
            end
         end
         ST_S_RD: begin
            state_in = ST_S_DIV;
            ch_in = 2'd0;
         end
         ST_S_DIV: begin
            if (ch_ff == 2'd0) ent_in = e_rd;
            if (rq_kind_ff == KIND_FADE && rq_dur_ff != 8'd0) begin
               div_start = 1'b1;
               state_in = ST_S_WAIT;
            end else begin
               ent_in.stp_r = '0; ent_in.stp_g = '0; ent_in.stp_b = '0;
               state_in = ST_S_WR;
            end
            if (ch_ff == 2'd0) begin
               // Divider reads the memory output through ent_ff next cycle.
               div_start = 1'b0;
               if (rq_kind_ff == KIND_FADE && rq_dur_ff != 8'd0)
                  state_in = ST_S_DIV;
               ch_in = 2'd3;
            end
            if (ch_ff == 2'd3) begin
               ch_in = 2'd0;
            end
         end
         ST_S_WAIT: begin
            if (div_done) begin
               case (ch_ff)
                  2'd0:    ent_in.stp_r = div_q;
                  2'd1:    ent_in.stp_g = div_q;
                  default: ent_in.stp_b = div_q;
               endcase
               if (ch_ff == 2'd2) begin
                  state_in = ST_S_WR;
               end else begin
                  ch_in = ch_ff + 2'd1;
                  state_in = ST_S_DIV;
               end
            end
         end
         ST_S_WR: begin
            e_we = 1'b1;
            e_wd = ent_ff;
            e_wd.kind = rq_kind_ff;
            e_wd.tgt = rq_tgt_ff;
            e_wd.dur = rq_dur_ff;
            e_wd.sframe = frame_ff + 32'(rq_dly_ff);
            state_in = ST_IDLE;
         end
         ST_T_RD: begin
            state_in = ST_T_UPD;
         end
         ST_T_UPD: begin
            ent_in = e_rd;
            state_in = ST_T_WR;
            ch_in = 2'd0;
            if (dlt > 0 && (e_rd.kind == KIND_ON || e_rd.kind == KIND_FADE)) begin
               ch_in = 2'd1;
               if (e_rd.kind == KIND_FADE && dlt <= 32'sd255
                   && dlt[7:0] <= e_rd.dur) begin
                  ch_in = 2'd2;
               end
            end
         end
         ST_T_WR: begin
            if (ch_ff == 2'd2) begin
               ent_in.cur_r = cl_r; ent_in.cur_g = cl_g; ent_in.cur_b = cl_b;
            end else if (ch_ff == 2'd1) begin
               ent_in.cur_r = tfx(ent_ff.tgt[23:16]);
               ent_in.cur_g = tfx(ent_ff.tgt[15:8]);
               ent_in.cur_b = tfx(ent_ff.tgt[7:0]);
            end
            e_we = (ch_ff != 2'd0);
            e_wd = ent_in;
            f_we = (ch_ff != 2'd0) && (pmap < 6'(NPIX));
            f_wd = {scale8(8'(ent_in.cur_r >>> FRAC_BITS), pct),
                    scale8(8'(ent_in.cur_g >>> FRAC_BITS), pct),
                    scale8(8'(ent_in.cur_b >>> FRAC_BITS), pct)};
            if (32'(idx_ff) == LED_COUNT - 1) begin
               state_in = ST_O_RD;
               pix_in = '0;
            end else begin
               idx_in = idx_ff + 1'b1;
               state_in = ST_T_RD;
            end
         end
         ST_O_RD: begin
            state_in = ST_O_SEND;
         end
         ST_O_SEND: begin
            if (load_px) begin
               if (32'(pix_ff) == NPIX - 1) begin
                  state_in = ST_O_LAST;
               end else begin
                  pix_in = pix_ff + 1'b1;
                  state_in = ST_O_RD;
               end
            end
         end
         ST_O_LAST: begin
            // The final pixel must leave before the next request is taken.
            if (rsp_valid_ff && rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // State, registered outputs and request capture.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         frame_ff     <= '0;
         idx_ff       <= '0;
         pix_ff       <= '0;
         ch_ff        <= '0;
         bright_ff    <= 3'd4;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         frame_ff <= frame_in;
         idx_ff   <= idx_in;
         pix_ff   <= pix_in;
         ch_ff    <= ch_in;
         if (csr_valid) bright_ff <= csr_brightness_level;
         if (load_px) begin
            rsp_valid_ff <= 1'b1;
            o_pos_ff  <= pix_ff;
            o_r_ff    <= f_rd[23:16];
            o_g_ff    <= f_rd[15:8];
            o_b_ff    <= f_rd[7:0];
            o_last_ff <= (32'(pix_ff) == NPIX - 1);
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      ent_ff <= ent_in;
      if (state_ff == ST_IDLE) begin
         led_ff     <= req_led;
         rq_tgt_ff  <= {req_target_red, req_target_green, req_target_blue};
         rq_kind_ff <= req_anim_kind;
         rq_dur_ff  <= req_duration;
         rq_dly_ff  <= req_start_delay;
      end
   end

   assign req_ready     = (state_ff == ST_IDLE);
   assign csr_ready     = 1'b1;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_position  = 4'(o_pos_ff);
   assign rsp_out_red   = o_r_ff;
   assign rsp_out_green = o_g_ff;
   assign rsp_out_blue  = o_b_ff;
   assign rsp_last      = o_last_ff;

   // Checks.
   a_no_req_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !req_ready) else $error("request taken during output");
   a_tick_count: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_func == FUNC_TICK |=> frame_ff == $past(frame_ff) + 32'd1)
      else $error("frame counter not advanced");
   a_clear_quiet: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLEAR |-> !rsp_valid_ff) else $error("output during clear");
   a_led_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_S_WR |-> 32'(led_ff) < LED_COUNT) else $error("bad LED slot");
endmodule
